// ----- src/msm_pkg.sv -----
// Shared types and codes for the stereo sample mixer.
`timescale 1ns / 1ps
package msm_pkg;

   // Command codes carried by an input item
   localparam logic [2:0] CMD_TICK       = 3'd0;
   localparam logic [2:0] CMD_LOAD       = 3'd1;
   localparam logic [2:0] CMD_DEFINE     = 3'd2;
   localparam logic [2:0] CMD_PLAY       = 3'd3;
   localparam logic [2:0] CMD_STOP_CHAN  = 3'd4;
   localparam logic [2:0] CMD_STOP_SOUND = 3'd5;

   // Play status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_CHAN = 2'd1;
   localparam logic [1:0] STATUS_BAD_SND = 2'd2;

   localparam logic [15:0] UNITY_GAIN = 16'd32768;
   localparam logic [16:0] MAX_FRAMES = 17'd65536;

   // Controls from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic mul;
      logic acc_left;
      logic acc_right;
   } mac_ctrl_type;

endpackage

// ----- src/msm_mac.sv -----
// Shared multiplier with Q1.15 truncation and the left/right accumulators.
`timescale 1ns / 1ps
module msm_mac
   import msm_pkg::*;
#(
   parameter int AccW = 20
) (
   input  logic                      clock,
   input  mac_ctrl_type              ctrl,
   input  logic signed [15:0]        sample,
   input  logic        [15:0]        gain,
   output logic signed [AccW-1:0]    acc_left,
   output logic signed [AccW-1:0]    acc_right
);

   logic signed [32:0]     prod_ff;
   logic signed [32:0]     biased;
   logic signed [32:0]     shifted;
   logic signed [15:0]     term;
   logic signed [AccW-1:0] acc_left_ff;
   logic signed [AccW-1:0] acc_right_ff;

   // Round toward zero: bias negative products before the shift
   always_comb begin
      biased  = prod_ff + (prod_ff[32] ? 33'sd32767 : 33'sd0);
      shifted = biased >>> 15;
      term    = shifted[15:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         prod_ff <= sample * $signed({1'b0, gain});
      end
      if (ctrl.clear) begin
         acc_left_ff  <= '0;
         acc_right_ff <= '0;
      end else begin
         if (ctrl.acc_left) begin
            acc_left_ff <= acc_left_ff + AccW'(term);
         end
         if (ctrl.acc_right) begin
            acc_right_ff <= acc_right_ff + AccW'(term);
         end
      end
   end

   assign acc_left  = acc_left_ff;
   assign acc_right = acc_right_ff;

endmodule

// ----- src/msm_sample_mem.sv -----
// Stereo sample memory: one write port, one registered read port.
`timescale 1ns / 1ps
module msm_sample_mem #(
   parameter int Depth = 65536,
   parameter int AddrW = 16
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [31:0]      wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [31:0]      rd_data
);

   logic [31:0] mem [Depth];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/multichannel_sample_mixer.sv -----
// Non-tick items: accepted in S_IDLE, executed in S_EXEC, handed over in S_DONE.
// Tick: a channel scan through S_CHECK, and per playing channel S_MOD, S_READ,
// S_MUL_L, S_MUL_R and S_ACC; S_MOD takes one step at 65536 frames. One shared
// multiplier handles left then right for each channel. One item at a time.
// Reset (synchronous, active high) frees all channels and slots; sample
// memory keeps its contents and is undefined until loaded.
`timescale 1ns / 1ps
module multichannel_sample_mixer
   import msm_pkg::*;
#(
   parameter int CHANNELS      = 8,
   parameter int SOUND_SLOTS   = 32,
   parameter int SAMPLE_FRAMES = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic [4:0]         req_channel,
   input  logic [4:0]         req_sound,
   input  logic [15:0]        req_volume,
   input  logic               req_loop,
   input  logic [15:0]        req_address,
   input  logic [16:0]        req_length,
   input  logic signed [15:0] req_sample_left,
   input  logic signed [15:0] req_sample_right,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_mix_left,
   output logic signed [15:0] rsp_mix_right,
   output logic               rsp_frame_valid,
   output logic [7:0]         rsp_finished_mask,
   output logic [4:0]         rsp_assigned_channel,
   output logic [1:0]         rsp_status
);

   localparam int ChW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SlW   = (SOUND_SLOTS > 1) ? $clog2(SOUND_SLOTS) : 1;
   localparam int AddrW = $clog2(SAMPLE_FRAMES);
   localparam int AccW  = 17 + $clog2(CHANNELS);

   // Largest shift k with SAMPLE_FRAMES << k still below 2^17, or -1
   function automatic int mod_top(input int frames);
      int k;
      int top;
      top = -1;
      for (k = 0; k < 18; k++) begin
         if ((longint'(frames) << k) < 64'd131072) begin
            top = k;
         end
      end
      return top;
   endfunction

   localparam int ModTop = mod_top(SAMPLE_FRAMES);
   localparam int ModK   = (ModTop > 0) ? ModTop : 0;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_CHECK, S_MOD, S_READ, S_MUL_L, S_MUL_R, S_ACC, S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Latched item
   logic [2:0]  cmd_ff, cmd_in;
   logic [4:0]  chan_ff, chan_in;
   logic [4:0]  sound_ff, sound_in;
   logic [15:0] volume_ff, volume_in;
   logic        loop_ff, loop_in;
   logic [15:0] address_ff, address_in;
   logic [16:0] length_ff, length_in;
   logic [31:0] samples_ff, samples_in;

   // Slot table
   logic        slot_used_ff   [SOUND_SLOTS];
   logic        slot_used_in   [SOUND_SLOTS];
   logic [15:0] slot_offset_ff [SOUND_SLOTS];
   logic [15:0] slot_offset_in [SOUND_SLOTS];
   logic [16:0] slot_frames_ff [SOUND_SLOTS];
   logic [16:0] slot_frames_in [SOUND_SLOTS];

   // Channel table
   logic        chan_active_ff [CHANNELS];
   logic        chan_active_in [CHANNELS];
   logic [4:0]  chan_slot_ff   [CHANNELS];
   logic [4:0]  chan_slot_in   [CHANNELS];
   logic [16:0] chan_pos_ff    [CHANNELS];
   logic [16:0] chan_pos_in    [CHANNELS];
   logic [15:0] chan_gain_ff   [CHANNELS];
   logic [15:0] chan_gain_in   [CHANNELS];
   logic        chan_repeat_ff [CHANNELS];
   logic        chan_repeat_in [CHANNELS];

   // Scan and result working registers
   logic [ChW-1:0] cnt_ff, cnt_in;
   logic [16:0]    addr_ff, addr_in;
   logic [3:0]     modk_ff, modk_in;
   logic [7:0]     fin_ff, fin_in;
   logic [4:0]     assigned_ff, assigned_in;
   logic [1:0]     status_ff, status_in;

   // Response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_left_ff, rsp_left_in;
   logic signed [15:0] rsp_right_ff, rsp_right_in;
   logic               rsp_frame_ff, rsp_frame_in;
   logic [7:0]         rsp_fin_ff, rsp_fin_in;
   logic [4:0]         rsp_assigned_ff, rsp_assigned_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               mem_wr_en;
   logic [31:0]        mem_rd_data;
   mac_ctrl_type       mac_ctrl;
   logic signed [15:0] mac_sample;
   logic signed [AccW-1:0] acc_left;
   logic signed [AccW-1:0] acc_right;

   logic [SlW-1:0] cur_slot;
   logic [16:0]    cur_frames;
   logic [16:0]    pos_eff;
   logic [16:0]    mod_step;
   logic           free_found;
   logic [4:0]     free_idx;

   // Lowest free channel
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int c = CHANNELS - 1; c >= 0; c--) begin
         if (!chan_active_ff[c]) begin
            free_found = 1'b1;
            free_idx   = 5'(c);
         end
      end
   end

   assign cur_slot   = SlW'(chan_slot_ff[cnt_ff]);
   assign cur_frames = slot_frames_ff[cur_slot];
   assign mod_step   = 17'(SAMPLE_FRAMES << modk_ff);

   // Sequencer next state
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      chan_in        = chan_ff;
      sound_in       = sound_ff;
      volume_in      = volume_ff;
      loop_in        = loop_ff;
      address_in     = address_ff;
      length_in      = length_ff;
      samples_in     = samples_ff;
      slot_used_in   = slot_used_ff;
      slot_offset_in = slot_offset_ff;
      slot_frames_in = slot_frames_ff;
      chan_active_in = chan_active_ff;
      chan_slot_in   = chan_slot_ff;
      chan_pos_in    = chan_pos_ff;
      chan_gain_in   = chan_gain_ff;
      chan_repeat_in = chan_repeat_ff;
      cnt_in         = cnt_ff;
      addr_in        = addr_ff;
      modk_in        = modk_ff;
      fin_in         = fin_ff;
      assigned_in    = assigned_ff;
      status_in      = status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_left_in     = rsp_left_ff;
      rsp_right_in    = rsp_right_ff;
      rsp_frame_in    = rsp_frame_ff;
      rsp_fin_in      = rsp_fin_ff;
      rsp_assigned_in = rsp_assigned_ff;
      rsp_status_in   = rsp_status_ff;
      mem_wr_en      = 1'b0;
      mac_ctrl       = '0;
      mac_sample     = $signed(mem_rd_data[15:0]);
      pos_eff        = chan_pos_ff[cnt_ff];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_command;
               chan_in    = req_channel;
               sound_in   = req_sound;
               volume_in  = req_volume;
               loop_in    = req_loop;
               address_in = req_address;
               length_in  = req_length;
               samples_in = {req_sample_right, req_sample_left};
               state_in   = S_EXEC;
            end
         end

         S_EXEC: begin
            fin_in      = '0;
            assigned_in = '0;
            status_in   = STATUS_OK;
            cnt_in      = '0;
            state_in    = S_DONE;
            case (cmd_ff)
               CMD_TICK: begin
                  mac_ctrl.clear = 1'b1;
                  state_in       = S_CHECK;
               end
               CMD_LOAD: begin
                  mem_wr_en = (32'(address_ff) < 32'(SAMPLE_FRAMES));
               end
               CMD_DEFINE: begin
                  if (32'(sound_ff) < 32'(SOUND_SLOTS)) begin
                     slot_offset_in[SlW'(sound_ff)] = address_ff;
                     slot_frames_in[SlW'(sound_ff)] =
                        (length_ff > MAX_FRAMES) ? MAX_FRAMES : length_ff;
                     slot_used_in[SlW'(sound_ff)] = (length_ff != '0);
                  end
               end
               CMD_PLAY: begin
                  if (32'(sound_ff) >= 32'(SOUND_SLOTS) || !slot_used_ff[SlW'(sound_ff)]) begin
                     status_in = STATUS_BAD_SND;
                  end else if (!free_found) begin
                     status_in = STATUS_NO_CHAN;
                  end else begin
                     chan_active_in[ChW'(free_idx)] = 1'b1;
                     chan_slot_in[ChW'(free_idx)]   = sound_ff;
                     chan_pos_in[ChW'(free_idx)]    = '0;
                     chan_gain_in[ChW'(free_idx)]   =
                        (volume_ff > UNITY_GAIN) ? UNITY_GAIN : volume_ff;
                     chan_repeat_in[ChW'(free_idx)] = loop_ff;
                     assigned_in = free_idx;
                  end
               end
               CMD_STOP_CHAN: begin
                  if (32'(chan_ff) < 32'(CHANNELS)) begin
                     chan_active_in[ChW'(chan_ff)] = 1'b0;
                     fin_in = 8'(32'd1 << chan_ff);
                  end
               end
               CMD_STOP_SOUND: begin
                  for (int c = 0; c < CHANNELS; c++) begin
                     if (chan_active_ff[c] && chan_slot_ff[c] == sound_ff) begin
                        chan_active_in[c] = 1'b0;
                        fin_in = fin_in | 8'(32'd1 << c);
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         // Decide what the current channel does on this tick
         S_CHECK: begin
            if (cnt_ff == ChW'(CHANNELS - 1)) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (chan_active_ff[cnt_ff]) begin
               if (!slot_used_ff[cur_slot] || cur_frames == '0) begin
                  chan_active_in[cnt_ff] = 1'b0;
               end else if (chan_pos_ff[cnt_ff] >= cur_frames && !chan_repeat_ff[cnt_ff]) begin
                  chan_active_in[cnt_ff] = 1'b0;
                  fin_in = fin_ff | 8'(32'd1 << cnt_ff);
               end else begin
                  if (chan_pos_ff[cnt_ff] >= cur_frames) begin
                     pos_eff = '0;
                  end
                  addr_in  = 17'(slot_offset_ff[cur_slot]) + pos_eff;
                  chan_pos_in[cnt_ff] = pos_eff + 17'd1;
                  cnt_in   = cnt_ff;
                  modk_in  = 4'(ModK);
                  state_in = (ModTop >= 0) ? S_MOD : S_READ;
               end
            end
         end

         // Reduce the read address modulo the memory depth
         S_MOD: begin
            if (addr_ff >= mod_step) begin
               addr_in = addr_ff - mod_step;
            end
            if (modk_ff == '0) begin
               state_in = S_READ;
            end else begin
               modk_in = modk_ff - 1'b1;
            end
         end

         S_READ: begin
            state_in = S_MUL_L;
         end

         S_MUL_L: begin
            mac_ctrl.mul = 1'b1;
            state_in     = S_MUL_R;
         end

         S_MUL_R: begin
            mac_sample        = $signed(mem_rd_data[31:16]);
            mac_ctrl.mul      = 1'b1;
            mac_ctrl.acc_left = 1'b1;
            state_in          = S_ACC;
         end

         S_ACC: begin
            mac_ctrl.acc_right = 1'b1;
            if (cnt_ff == ChW'(CHANNELS - 1)) begin
               state_in = S_DONE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_CHECK;
            end
         end

         // Hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_frame_in    = (cmd_ff == CMD_TICK);
               rsp_fin_in      = fin_ff;
               rsp_assigned_in = assigned_ff;
               rsp_status_in   = status_ff;
               rsp_left_in     = '0;
               rsp_right_in    = '0;
               if (cmd_ff == CMD_TICK) begin
                  rsp_left_in = (acc_left > AccW'(32767)) ? 16'sh7fff :
                                (acc_left < -AccW'(32768)) ? -16'sh8000 :
                                acc_left[15:0];
                  rsp_right_in = (acc_right > AccW'(32767)) ? 16'sh7fff :
                                 (acc_right < -AccW'(32768)) ? -16'sh8000 :
                                 acc_right[15:0];
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SOUND_SLOTS; s++) begin
            slot_used_ff[s]   <= 1'b0;
            slot_frames_ff[s] <= '0;
         end
         for (int c = 0; c < CHANNELS; c++) begin
            chan_active_ff[c] <= 1'b0;
         end
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         slot_used_ff   <= slot_used_in;
         slot_frames_ff <= slot_frames_in;
         chan_active_ff <= chan_active_in;
      end
      cmd_ff          <= cmd_in;
      chan_ff         <= chan_in;
      sound_ff        <= sound_in;
      volume_ff       <= volume_in;
      loop_ff         <= loop_in;
      address_ff      <= address_in;
      length_ff       <= length_in;
      samples_ff      <= samples_in;
      slot_offset_ff  <= slot_offset_in;
      chan_slot_ff    <= chan_slot_in;
      chan_pos_ff     <= chan_pos_in;
      chan_gain_ff    <= chan_gain_in;
      chan_repeat_ff  <= chan_repeat_in;
      cnt_ff          <= cnt_in;
      addr_ff         <= addr_in;
      modk_ff         <= modk_in;
      fin_ff          <= fin_in;
      assigned_ff     <= assigned_in;
      status_ff       <= status_in;
      rsp_left_ff     <= rsp_left_in;
      rsp_right_ff    <= rsp_right_in;
      rsp_frame_ff    <= rsp_frame_in;
      rsp_fin_ff      <= rsp_fin_in;
      rsp_assigned_ff <= rsp_assigned_in;
      rsp_status_ff   <= rsp_status_in;
   end

   msm_sample_mem #(
      .Depth (SAMPLE_FRAMES),
      .AddrW (AddrW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (AddrW'(address_ff)),
      .wr_data (samples_ff),
      .rd_addr (AddrW'(addr_ff)),
      .rd_data (mem_rd_data)
   );

   msm_mac #(
      .AccW (AccW)
   ) u_mac (
      .clock     (clock),
      .ctrl      (mac_ctrl),
      .sample    (mac_sample),
      .gain      (chan_gain_ff[cnt_ff]),
      .acc_left  (acc_left),
      .acc_right (acc_right)
   );

   assign req_ready            = (state_ff == S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_mix_left         = rsp_left_ff;
   assign rsp_mix_right        = rsp_right_ff;
   assign rsp_frame_valid      = rsp_frame_ff;
   assign rsp_finished_mask    = rsp_fin_ff;
   assign rsp_assigned_channel = rsp_assigned_ff;
   assign rsp_status           = rsp_status_ff;

endmodule

// ----- src/msm_checker.sv -----
// Port-level checks for the mixer, bound to the top level.
`timescale 1ns / 1ps
module msm_checker
   import msm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_mix_left,
   input logic               rsp_frame_valid,
   input logic [4:0]         rsp_assigned_channel,
   input logic [1:0]         rsp_status
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mix_left))
      else $error("stalled result changed");

   // One item at a time: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted two items back to back");

   // A frame carries no play outcome
   a_frame_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_valid |-> rsp_status == STATUS_OK &&
      rsp_assigned_channel == 5'd0)
      else $error("frame with play status");

   // Failed play assigns no channel
   a_fail_chan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_assigned_channel == 5'd0 &&
      rsp_status != 2'd3)
      else $error("bad status or channel on failed play");

endmodule

bind multichannel_sample_mixer msm_checker u_msm_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_mix_left         (rsp_mix_left),
   .rsp_frame_valid      (rsp_frame_valid),
   .rsp_assigned_channel (rsp_assigned_channel),
   .rsp_status           (rsp_status)
);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the stereo sample mixer, with its own behavioural predictor.
`timescale 1ns / 1ps
module tb_top;
   import msm_pkg::*;

   localparam int NUM_CHANS = 8;
   localparam int NUM_SLOTS = 32;
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   typedef struct {
      logic [2:0]         command;
      logic [4:0]         channel;
      logic [4:0]         sound;
      logic [15:0]        volume;
      logic               loop;
      logic [15:0]        address;
      logic [16:0]        length;
      logic signed [15:0] sample_left;
      logic signed [15:0] sample_right;
   } mixer_req_type;

   typedef struct {
      logic signed [15:0] mix_left;
      logic signed [15:0] mix_right;
      logic               frame_valid;
      logic [7:0]         finished_mask;
      logic [4:0]         assigned_channel;
      logic [1:0]         status;
   } mixer_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_command = '0;
   logic [4:0] req_channel = '0;
   logic [4:0] req_sound = '0;
   logic [15:0] req_volume = '0;
   logic req_loop = 1'b0;
   logic [15:0] req_address = '0;
   logic [16:0] req_length = '0;
   logic signed [15:0] req_sample_left = '0;
   logic signed [15:0] req_sample_right = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_mix_left;
   logic signed [15:0] rsp_mix_right;
   logic rsp_frame_valid;
   logic [7:0] rsp_finished_mask;
   logic [4:0] rsp_assigned_channel;
   logic [1:0] rsp_status;

   multichannel_sample_mixer i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_channel(req_channel), .req_sound(req_sound),
      .req_volume(req_volume), .req_loop(req_loop), .req_address(req_address),
      .req_length(req_length), .req_sample_left(req_sample_left),
      .req_sample_right(req_sample_right),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_mix_left(rsp_mix_left), .rsp_mix_right(rsp_mix_right),
      .rsp_frame_valid(rsp_frame_valid), .rsp_finished_mask(rsp_finished_mask),
      .rsp_assigned_channel(rsp_assigned_channel), .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   // Mirror of the mixer state
   logic [31:0] sample_store [int];
   logic        slot_in_use [NUM_SLOTS];
   logic [15:0] slot_start [NUM_SLOTS];
   logic [16:0] slot_len [NUM_SLOTS];
   logic        voice_on [NUM_CHANS];
   logic [4:0]  voice_slot [NUM_CHANS];
   logic [16:0] voice_pos [NUM_CHANS];
   logic [15:0] voice_gain [NUM_CHANS];
   logic        voice_repeat [NUM_CHANS];

   mixer_rsp_type pending_rsp [$];
   int errors = 0;
   int items_sent = 0;
   int frames_mixed = 0;
   int frames_checked = 0;
   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;
   int rsp_hold = 0;

   // Truncating Q1.15 scale of one sample
   function automatic int gain_scale(logic [15:0] smp, logic [15:0] gain);
      int s;
      s = int'($signed(smp));
      return (s * int'(gain)) / 32768;
   endfunction

   function automatic logic signed [15:0] clamp16(int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Works out one result and advances the mirrored state
   function automatic mixer_rsp_type mix_predict(mixer_req_type r);
      mixer_rsp_type o;
      int acc_l, acc_r;
      logic [4:0] s;
      logic [15:0] addr;
      logic [31:0] word;
      logic [16:0] len;
      o = '{default: '0};
      acc_l = 0;
      acc_r = 0;
      case (r.command)
         CMD_TICK: begin
            o.frame_valid = 1'b1;
            for (int c = 0; c < NUM_CHANS; c++) begin
               if (!voice_on[c]) continue;
               s = voice_slot[c];
               if (!slot_in_use[s] || slot_len[s] == 0) begin
                  voice_on[c] = 1'b0;
                  continue;
               end
               if (voice_pos[c] >= slot_len[s]) begin
                  if (voice_repeat[c]) voice_pos[c] = '0;
                  else begin
                     voice_on[c] = 1'b0;
                     o.finished_mask[c] = 1'b1;
                     continue;
                  end
               end
               addr = slot_start[s] + voice_pos[c][15:0];
               word = sample_store.exists(addr) ? sample_store[addr] : 32'd0;
               acc_l += gain_scale(word[15:0], voice_gain[c]);
               acc_r += gain_scale(word[31:16], voice_gain[c]);
               voice_pos[c]++;
            end
            o.mix_left = clamp16(acc_l);
            o.mix_right = clamp16(acc_r);
         end
         CMD_LOAD: sample_store[r.address] = {r.sample_right, r.sample_left};
         CMD_DEFINE: begin
            len = (r.length > MAX_FRAMES) ? MAX_FRAMES : r.length;
            slot_start[r.sound] = r.address;
            slot_len[r.sound] = len;
            slot_in_use[r.sound] = (len != 0);
         end
         CMD_PLAY: begin
            if (!slot_in_use[r.sound]) o.status = STATUS_BAD_SND;
            else begin
               o.status = STATUS_NO_CHAN;
               for (int c = 0; c < NUM_CHANS; c++) begin
                  if (voice_on[c]) continue;
                  voice_on[c] = 1'b1;
                  voice_slot[c] = r.sound;
                  voice_pos[c] = '0;
                  voice_gain[c] = (r.volume > UNITY_GAIN) ? UNITY_GAIN : r.volume;
                  voice_repeat[c] = r.loop;
                  o.assigned_channel = c[4:0];
                  o.status = STATUS_OK;
                  break;
               end
            end
         end
         CMD_STOP_CHAN: begin
            if (r.channel < NUM_CHANS) begin
               voice_on[r.channel] = 1'b0;
               o.finished_mask[r.channel] = 1'b1;
            end
         end
         CMD_STOP_SOUND: begin
            for (int c = 0; c < NUM_CHANS; c++)
               if (voice_on[c] && voice_slot[c] == r.sound) begin
                  voice_on[c] = 1'b0;
                  o.finished_mask[c] = 1'b1;
               end
         end
         default: ;
      endcase
      return o;
   endfunction

   // Random item with every field filled
   function automatic mixer_req_type any_req(logic [2:0] cmd);
      mixer_req_type r;
      r.command = cmd;
      r.channel = 5'($urandom_range(0, 31));
      r.sound = 5'($urandom_range(0, 31));
      r.volume = 16'($urandom);
      r.loop = 1'($urandom_range(0, 1));
      r.address = 16'($urandom);
      r.length = 17'($urandom);
      r.sample_left = 16'($urandom);
      r.sample_right = 16'($urandom);
      return r;
   endfunction

   // Offers one item, waits for acceptance, then logs its expected result
   task automatic send_item(mixer_req_type r);
      int gap;
      gap = sender_idles ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_command <= r.command;
      req_channel <= r.channel;
      req_sound <= r.sound;
      req_volume <= r.volume;
      req_loop <= r.loop;
      req_address <= r.address;
      req_length <= r.length;
      req_sample_left <= r.sample_left;
      req_sample_right <= r.sample_right;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(mix_predict(r));
      items_sent++;
      if (r.command == CMD_TICK) frames_mixed++;
   endtask

   // A tick, preceded by loads of any frame it would read that was never written
   task automatic send_tick();
      logic [4:0] s;
      logic [16:0] p;
      logic [15:0] addr;
      mixer_req_type ld;
      for (int c = 0; c < NUM_CHANS; c++) begin
         if (!voice_on[c]) continue;
         s = voice_slot[c];
         if (!slot_in_use[s] || slot_len[s] == 0) continue;
         p = voice_pos[c];
         if (p >= slot_len[s]) begin
            if (!voice_repeat[c]) continue;
            p = '0;
         end
         addr = slot_start[s] + p[15:0];
         if (!sample_store.exists(addr)) begin
            ld = any_req(CMD_LOAD);
            ld.address = addr;
            send_item(ld);
         end
      end
      send_item(any_req(CMD_TICK));
   endtask

   task automatic send_define(int slot, int offset, int len);
      mixer_req_type r;
      r = any_req(CMD_DEFINE);
      r.sound = 5'(slot);
      r.address = 16'(offset);
      r.length = 17'(len);
      send_item(r);
   endtask

   task automatic send_play(int slot, int vol, bit rpt);
      mixer_req_type r;
      r = any_req(CMD_PLAY);
      r.sound = 5'(slot);
      r.volume = 16'(vol);
      r.loop = rpt;
      send_item(r);
   endtask

   task automatic send_load(int addr, int sl, int sr);
      mixer_req_type r;
      r = any_req(CMD_LOAD);
      r.address = 16'(addr);
      r.sample_left = 16'(sl);
      r.sample_right = 16'(sr);
      send_item(r);
   endtask

   task automatic send_stop(logic [2:0] cmd, int chan, int slot);
      mixer_req_type r;
      r = any_req(cmd);
      r.channel = 5'(chan);
      r.sound = 5'(slot);
      send_item(r);
   endtask

   // Extremes, wrap of the read address, bad slots and channels, unknown codes
   task automatic test_directed();
      send_load(0, -32768, 32767);
      send_load(1, 32767, -32768);
      send_load(65535, -1, 1);
      send_define(0, 0, 2);
      send_define(31, 65535, 131071);
      send_play(31, 65535, 1'b0);
      send_play(0, 32768, 1'b1);
      send_play(5, 100, 1'b0);
      send_tick();
      send_tick();
      send_tick();
      send_stop(CMD_STOP_CHAN, 20, 0);
      send_stop(CMD_STOP_CHAN, 7, 0);
      send_stop(CMD_STOP_SOUND, 0, 31);
      send_define(0, 0, 0);
      send_tick();
      send_item(any_req(CMD_SPARE_6));
      send_item(any_req(CMD_SPARE_7));
      send_define(1, 0, 1);
      send_play(1, 0, 1'b0);
      send_tick();
      send_tick();
   endtask

   // Every channel busy, a play with no channel left, then a saturated mix
   task automatic test_channel_pool();
      send_load(2, 32767, -32768);
      send_define(2, 2, 1);
      for (int i = 0; i < NUM_CHANS; i++) send_play(2, 32768, 1'b1);
      send_play(2, 32768, 1'b0);
      send_tick();
      send_tick();
      send_stop(CMD_STOP_SOUND, 0, 2);
   endtask

   // Mostly well-formed play sequences with random content, some noise
   task automatic test_random(int n);
      int pick, len;
      mixer_req_type r;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) send_tick();
         else if (pick < 52) begin
            r = any_req(CMD_LOAD);
            if ($urandom_range(0, 4) != 0) r.address = 16'($urandom_range(0, 300));
            send_item(r);
         end else if (pick < 62) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) len = $urandom_range(1, 24);
            else if (pick < 16) len = 0;
            else if (pick < 18) len = $urandom_range(25, 2000);
            else if (pick < 19) len = 65536;
            else len = $urandom_range(65537, 131071);
            send_define($urandom_range(0, 31),
                        ($urandom_range(0, 4) != 0) ? $urandom_range(0, 255) : $urandom,
                        len);
         end else if (pick < 80) begin
            r = any_req(CMD_PLAY);
            if ($urandom_range(0, 1)) r.volume = 16'($urandom_range(0, 32768));
            send_item(r);
         end else if (pick < 89) send_item(any_req(CMD_STOP_CHAN));
         else if (pick < 97) send_item(any_req(CMD_STOP_SOUND));
         else send_item(any_req($urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7));
      end
   endtask

   // Receiver held off for a long stretch so the mixer backs up
   task automatic test_backpressure();
      rsp_hold = 400;
      sender_idles = 1'b0;
      test_random(60);
      sender_idles = 1'b1;
   endtask

   // Result side: random stalls and the long hold-off
   initial begin
      int gap;
      gap = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (rsp_ready && rsp_valid) begin
            gap = receiver_idles ? $urandom_range(0, 8) : 0;
            if (gap > 0) rsp_ready <= 1'b0;
         end else if (!rsp_ready) begin
            if (gap > 0) gap--;
            if (gap == 0) rsp_ready <= 1'b1;
         end
      end
   end

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      mixer_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected", $time);
         end else begin
            e = pending_rsp.pop_front();
            check_field("mix_left", e.mix_left, rsp_mix_left);
            check_field("mix_right", e.mix_right, rsp_mix_right);
            check_field("frame_valid", e.frame_valid, rsp_frame_valid);
            check_field("finished_mask", e.finished_mask, rsp_finished_mask);
            check_field("assigned_channel", e.assigned_channel, rsp_assigned_channel);
            check_field("status", e.status, rsp_status);
            if (e.frame_valid) frames_checked++;
         end
      end
   end

   initial begin
      #20ms;
      $display("multichannel_sample_mixer regression: fail");
      $finish;
   end

   // Test sequence
   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_in_use[i] = 1'b0;
         slot_start[i] = '0;
         slot_len[i] = '0;
      end
      for (int c = 0; c < NUM_CHANS; c++) begin
         voice_on[c] = 1'b0;
         voice_slot[c] = '0;
         voice_pos[c] = '0;
         voice_gain[c] = '0;
         voice_repeat[c] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_channel_pool();
      test_random(800);
      test_backpressure();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      test_random(300);
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      test_random(650);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Sent %0d items, %0d of them mix ticks; %0d frames checked.",
               items_sent, frames_mixed, frames_checked);
      $display("Covered loads, slot defines, plays, stops, full pool and back-pressure.");
      if (errors == 0 && pending_rsp.size() == 0)
         $display("multichannel_sample_mixer regression: pass");
      else
         $display("multichannel_sample_mixer regression: fail");
      $finish;
   end

endmodule
